// ----- rtl/core/rrb_pkg.sv -----
// Shared types and constants for the RTP reorder and release buffer.
// Used by rrb_acct, rrb_seq and rtp_reorder_release_buffer.
package rrb_pkg;

    // Field widths of the stream items
    localparam int SEQ_W    = 16;
    localparam int TS_W     = 32;
    localparam int HANDLE_W = 16;
    localparam int SAMP_W   = 13;
    localparam int GRAN_W   = 64;
    localparam int PKT_W    = 32;
    localparam int KIND_W   = 2;
    localparam int THR_W    = 32;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 128;

    // Defaults of the top-level parameters
    localparam int WINDOW_SLOTS_DEF = 16;
    localparam int HANDLE_BITS_DEF  = 16;

    // Register and counter reset values
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd9600;
    localparam logic [PKT_W-1:0] PKT_NO_RESET    = 32'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PACKET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SILENCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_SORT,
        S_RD,
        S_JUMP,
        S_ADV,
        S_EMIT,
        S_STORE,
        S_DROP
    } rrb_state_t;

    // Commands from the sequencer to the accounting unit
    typedef struct packed {
        logic            start;
        logic [TS_W-1:0] start_ts;
        logic            jump;
        logic            slot_valid;
        logic            adv;
        logic            emit;
    } rrb_acct_cmd_t;

    // Status from the accounting unit
    typedef struct packed {
        logic [GRAN_W-1:0] granule;
        logic [PKT_W-1:0]  pkt_no;
        logic              subst;
        logic              subst_next;
        logic [SAMP_W-1:0] samples;
    } rrb_acct_stat_t;

endpackage

// ----- rtl/core/rrb_slot_mem.sv -----
// Slot payload memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module rrb_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 61
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port, read data registered while re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rrb_acct.sv -----
// Accounting unit: expected timestamp, granule and segment counts, packet
// number and the substantial threshold register. Depends on rrb_pkg.
module rrb_acct
    import rrb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  rrb_acct_cmd_t         cmd,
    input  logic [TS_W-1:0]       rd_ts,
    input  logic [SAMP_W-1:0]     rd_samples,
    output rrb_acct_stat_t        stat
);

    logic [THR_W-1:0]  thr_reg;
    logic [TS_W-1:0]   exp_ts_reg,   exp_ts_next;
    logic [GRAN_W-1:0] granule_reg,  granule_next;
    logic [GRAN_W-1:0] seg_reg,      seg_next;
    logic [SAMP_W-1:0] last_reg,     last_next;
    logic [SAMP_W-1:0] cur_reg,      cur_next;
    logic [PKT_W-1:0]  pkt_reg,      pkt_next;
    logic              subst_reg,    subst_next;
    logic [TS_W-1:0]   ts_diff;
    logic              thr_hit;

    assign ts_diff = rd_ts - exp_ts_reg;
    assign thr_hit = (seg_reg >= {{(GRAN_W-THR_W){1'b0}}, thr_reg});

    // Next-state of the counters, one step per command
    always_comb
    begin
        exp_ts_next  = exp_ts_reg;
        granule_next = granule_reg;
        seg_next     = seg_reg;
        last_next    = last_reg;
        cur_next     = cur_reg;
        pkt_next     = pkt_reg;
        subst_next   = subst_reg;
        if (cmd.start)
        begin
            exp_ts_next = cmd.start_ts;
        end
        if (cmd.jump)
        begin
            // resync to the slot timestamp and pick the item length
            if (cmd.slot_valid)
            begin
                granule_next = granule_reg + {{(GRAN_W-TS_W){ts_diff[TS_W-1]}}, ts_diff};
                exp_ts_next  = rd_ts;
                cur_next     = rd_samples;
                last_next    = rd_samples;
            end
            else
            begin
                cur_next = last_reg;
            end
        end
        if (cmd.adv)
        begin
            granule_next = granule_reg + GRAN_W'(cur_reg);
            exp_ts_next  = exp_ts_reg + TS_W'(cur_reg);
            seg_next     = seg_reg + GRAN_W'(cur_reg);
        end
        if (cmd.emit)
        begin
            subst_next = subst_reg | thr_hit;
            pkt_next   = pkt_reg + 1'b1;
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RESET;
            exp_ts_reg  <= '0;
            granule_reg <= '0;
            seg_reg     <= '0;
            last_reg    <= '0;
            pkt_reg     <= PKT_NO_RESET;
            subst_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            exp_ts_reg  <= exp_ts_next;
            granule_reg <= granule_next;
            seg_reg     <= seg_next;
            last_reg    <= last_next;
            pkt_reg     <= pkt_next;
            subst_reg   <= subst_next;
        end
    end

    // Length of the item being released
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign stat.granule    = granule_reg;
    assign stat.pkt_no     = pkt_reg;
    assign stat.subst      = subst_reg;
    assign stat.subst_next = subst_reg | thr_hit;
    assign stat.samples    = cur_reg;

endmodule

// ----- rtl/core/rrb_seq.sv -----
// Sequencer: input capture, slot index, window valid bits, release walk and
// the output register. Depends on rrb_pkg; drives rrb_slot_mem and rrb_acct.
module rrb_seq
    import rrb_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [S_DATA_W-1:0]                   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [M_DATA_W-1:0]                   m_tdata,
    output logic [KIND_W-1:0]                     m_tuser,
    output logic                                  m_tlast,
    output logic                                  mem_we,
    output logic [$clog2(WINDOW_SLOTS)-1:0]       mem_waddr,
    output logic [TS_W+SAMP_W+((HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W)-1:0]
                                                  mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(WINDOW_SLOTS)-1:0]       mem_raddr,
    input  logic [((HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W)-1:0]
                                                  rd_handle,
    output rrb_acct_cmd_t                         acct_cmd,
    input  rrb_acct_stat_t                        acct_stat
);

    localparam int HBE     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int IDX_W   = $clog2(WINDOW_SLOTS);
    localparam int MUL_W   = 25;
    localparam int PROD_W  = SEQ_W + MUL_W;
    localparam int QW_W    = 24;
    localparam logic [MUL_W-1:0] MOD_MUL = MUL_W'((1 << 24) / WINDOW_SLOTS + 1);
    localparam logic [SEQ_W-1:0] WIN_LAST = SEQ_W'(WINDOW_SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SLOTS - 1);

    rrb_state_t state_reg, state_next;

    logic                    started_reg,  started_next;
    logic [SEQ_W-1:0]        exp_seq_reg,  exp_seq_next;
    logic [IDX_W-1:0]        head_reg,     head_next;
    logic [WINDOW_SLOTS-1:0] valid_reg,    valid_next;
    logic                    flushing_reg, flushing_next;
    logic [IDX_W-1:0]        fcnt_reg,     fcnt_next;
    logic                    m_valid_reg,  m_valid_next;

    // payload registers
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  q_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              win_reg;
    logic              stale_reg;
    logic              first_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [HBE-1:0]    handle_reg;
    logic [SAMP_W-1:0] samples_reg;
    logic              cur_valid_reg;
    logic [HBE-1:0]    cur_handle_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [SAMP_W-1:0] out_samples_reg;
    logic [GRAN_W-1:0] out_gran_reg;
    logic [PKT_W-1:0]  out_pkt_reg;
    logic              out_subst_reg;
    logic              out_last_reg;

    logic [SEQ_W-1:0]  in_seq;
    logic [SEQ_W-1:0]  exp_eff;
    logic [SEQ_W-1:0]  diff;
    logic [PROD_W-1:0] prod;
    logic [QW_W-1:0]   qw;
    logic [QW_W-1:0]   rem_full;
    logic [IDX_W-1:0]  head_inc;
    logic              accept;
    logic              out_free;
    logic              load_out;
    logic [KIND_W-1:0] load_kind;
    logic [HANDLE_W-1:0] load_handle;
    logic [SAMP_W-1:0] load_samples;
    logic [GRAN_W-1:0] load_gran;
    logic [PKT_W-1:0]  load_pkt;
    logic              load_subst;
    logic              load_last;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Window distance of the arriving item
    assign in_seq  = s_tdata[SEQ_W-1:0];
    assign exp_eff = started_reg ? exp_seq_reg : in_seq;
    assign diff    = in_seq - exp_eff;

    // Slot index: quotient by reciprocal, then remainder from the registered quotient
    assign prod     = PROD_W'(in_seq) * PROD_W'(MOD_MUL);
    assign qw       = QW_W'(q_reg) * QW_W'(WINDOW_SLOTS);
    assign rem_full = QW_W'(seq_reg) - qw;

    // Slot of the next expected sequence
    always_comb
    begin
        if (exp_seq_reg == '1)
        begin
            head_inc = '0;
        end
        else if (head_reg == IDX_LAST)
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + 1'b1;
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        exp_seq_next  = exp_seq_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        flushing_next = flushing_reg;
        fcnt_next     = fcnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        acct_cmd      = '0;
        load_out      = 1'b0;
        load_kind     = KIND_PACKET;
        load_handle   = '0;
        load_samples  = acct_stat.samples;
        load_gran     = acct_stat.granule;
        load_pkt      = acct_stat.pkt_no;
        load_subst    = acct_stat.subst_next;
        load_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    started_next      = 1'b1;
                    exp_seq_next      = exp_eff;
                    acct_cmd.start    = !started_reg;
                    acct_cmd.start_ts = s_tdata[SEQ_W +: TS_W];
                    state_next        = S_MOD;
                end
            end
            S_MOD:
            begin
                if (first_reg)
                begin
                    head_next = rem_full[IDX_W-1:0];
                end
                state_next = S_SORT;
            end
            S_SORT:
            begin
                if (win_reg)
                begin
                    // store in its slot, release if the head is now filled
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    if (valid_reg[head_reg] || (idx_reg == head_reg))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (stale_reg)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    flushing_next = 1'b1;
                    fcnt_next     = '0;
                    state_next    = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_JUMP;
            end
            S_JUMP:
            begin
                acct_cmd.jump       = 1'b1;
                acct_cmd.slot_valid = cur_valid_reg;
                state_next          = S_ADV;
            end
            S_ADV:
            begin
                acct_cmd.adv = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    acct_cmd.emit        = 1'b1;
                    load_out             = 1'b1;
                    load_kind            = cur_valid_reg ? KIND_PACKET : KIND_SILENCE;
                    load_handle          = cur_valid_reg ? HANDLE_W'(cur_handle_reg) : '0;
                    valid_next[head_reg] = 1'b0;
                    exp_seq_next         = exp_seq_reg + 1'b1;
                    head_next            = head_inc;
                    if (flushing_reg)
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                        if (fcnt_reg == IDX_LAST)
                        begin
                            state_next = S_STORE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else if (valid_reg[head_inc] && (head_inc != head_reg))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        load_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_STORE:
            begin
                // place the flushing item at the new head
                mem_we               = 1'b1;
                mem_waddr            = head_reg;
                valid_next[head_reg] = 1'b1;
                flushing_next        = 1'b0;
                state_next           = S_RD;
            end
            S_DROP:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    load_kind    = KIND_DROP;
                    load_handle  = HANDLE_W'(handle_reg);
                    load_samples = '0;
                    load_subst   = acct_stat.subst;
                    load_last    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    assign mem_wdata = {ts_reg, samples_reg, handle_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            started_reg  <= 1'b0;
            exp_seq_reg  <= '0;
            head_reg     <= '0;
            valid_reg    <= '0;
            flushing_reg <= 1'b0;
            fcnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            exp_seq_reg  <= exp_seq_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
            flushing_reg <= flushing_next;
            fcnt_reg     <= fcnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture the accepted item, its slot index and the slot status and handle of each release
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg     <= in_seq;
            q_reg       <= prod[SEQ_W+24-1:24];
            win_reg     <= (diff <= WIN_LAST);
            stale_reg   <= diff[SEQ_W-1];
            first_reg   <= !started_reg;
            ts_reg      <= s_tdata[SEQ_W +: TS_W];
            handle_reg  <= s_tdata[SEQ_W+TS_W +: HBE];
            samples_reg <= s_tdata[SEQ_W+TS_W+HANDLE_W +: SAMP_W];
        end
        if (state_reg == S_MOD)
        begin
            idx_reg <= rem_full[IDX_W-1:0];
        end
        if (state_reg == S_RD)
        begin
            cur_valid_reg <= valid_reg[head_reg];
        end
        if (state_reg == S_JUMP)
        begin
            cur_handle_reg <= rd_handle;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg    <= load_kind;
            out_handle_reg  <= load_handle;
            out_samples_reg <= load_samples;
            out_gran_reg    <= load_gran;
            out_pkt_reg     <= load_pkt;
            out_subst_reg   <= load_subst;
            out_last_reg    <= load_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_subst_reg, out_pkt_reg, out_gran_reg,
                       out_samples_reg, out_handle_reg};

endmodule

// ----- rtl/core/rtp_reorder_release_buffer.sv -----
// RTP reorder and release buffer: top level.
// Depends on rrb_pkg, rrb_slot_mem, rrb_acct and rrb_seq.
//
// Usage:
//   s_* stream carries arriving packets (sequence, timestamp, handle, length).
//   m_* stream carries results: released packets, silence fillers and stale
//   drops, with m_tlast on the final result that an input item causes.
//   cfg_we/cfg_wdata write the substantial-segment threshold (reset 9600).
// Operation:
//   Each item is first classified against the window. Each release walks
//   the slot memory in the steps read, timestamp resync, advance and emit.
//   A flush releases every slot, stores the item and releases it. The walk
//   over the slot memory is sequential; one item is worked on at a time.
// Reset empties all slots, clears the counters and the output valid flag;
// packet numbers start at 2. When the receiver stalls, the result holds in
// the output register and the walk waits at its emit step.
module rtp_reorder_release_buffer
    import rrb_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // seq_number, rtp_timestamp, packet_handle, packet_samples, zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    // out_handle, out_samples, granule_position, packet_number, substantial,
    // zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    // result_kind
    output logic [KIND_W-1:0]     m_tuser,
    // last_of_run
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata
);

    localparam int HBE   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int IDX_W = $clog2(WINDOW_SLOTS);
    localparam int MEM_W = TS_W + SAMP_W + HBE;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [MEM_W-1:0]  mem_rdata;
    rrb_acct_cmd_t     acct_cmd;
    rrb_acct_stat_t    acct_stat;

    rrb_slot_mem #(
        .DEPTH  (WINDOW_SLOTS),
        .DATA_W (MEM_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rrb_acct u_acct (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (acct_cmd),
        .rd_ts      (mem_rdata[MEM_W-1 -: TS_W]),
        .rd_samples (mem_rdata[HBE +: SAMP_W]),
        .stat       (acct_stat)
    );

    rrb_seq #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .rd_handle (mem_rdata[HBE-1:0]),
        .acct_cmd  (acct_cmd),
        .acct_stat (acct_stat)
    );

    // Kind is one of the three result codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_PACKET) || (m_tuser == KIND_SILENCE) ||
                     (m_tuser == KIND_DROP))
        else $error("invalid result kind");

    // Silence carries no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SILENCE) |-> (m_tdata[15:0] == '0))
        else $error("silence filler with nonzero handle");

    // A drop ends its run and accounts for no samples
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DROP) |-> m_tlast && (m_tdata[28:16] == '0))
        else $error("drop result malformed");

    // No item is taken while a result walk is underway
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during processing");

endmodule
